FILE: rtl/pmb_pkg.sv
package pmb_pkg;

  localparam int unsigned NumDestDefault   = 16;
  localparam int unsigned BatchDepthDefault = 16;
  localparam int unsigned MsgBitsDefault   = 64;

  localparam int unsigned DEST_W  = 4;
  localparam int unsigned MSG_W   = 64;
  localparam int unsigned LIMIT_W = 5;

  localparam logic [LIMIT_W-1:0] LimitReset = 5'd16;

  localparam logic ModeSend  = 1'b0;
  localparam logic ModeFlush = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [DEST_W-1:0] dest;
    logic [MSG_W-1:0]  message;
    logic              link_accepts;
  } pmb_req_t;

  typedef struct packed {
    logic              has_message;
    logic [DEST_W-1:0] out_dest;
    logic [MSG_W-1:0]  out_message;
    logic              last;
    logic              accepted;
  } pmb_res_t;

  typedef enum logic {
    StIdle,
    StEmit
  } pmb_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic emit_step;
  } pmb_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_emit;
    logic at_last;
  } pmb_sts_t;

endpackage

FILE: rtl/pmb_ctrl.sv
module pmb_ctrl
  import pmb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  pmb_sts_t sts_i,
  output pmb_cmd_t cmd_o,
  output logic     busy_o
);

  pmb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o.accept    = 1'b0;
    cmd_o.emit_step = 1'b0;
    busy_o         = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.need_emit) begin
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        busy_o          = 1'b1;
        cmd_o.emit_step = 1'b1;
        if (sts_i.at_last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

FILE: rtl/pmb_datapath.sv
module pmb_datapath
  import pmb_pkg::*;
#(
  parameter int unsigned NUM_DEST    = NumDestDefault,
  parameter int unsigned BATCH_DEPTH = BatchDepthDefault,
  parameter int unsigned MSG_BITS    = MsgBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  input  pmb_req_t           req_i,
  input  pmb_cmd_t           cmd_i,
  output pmb_sts_t           sts_o,
  output logic               res_valid_o,
  output pmb_res_t           res_o
);

  // Only destinations that the dest field can name get storage.
  localparam int unsigned DestSlots = (NUM_DEST < (1 << DEST_W)) ? NUM_DEST : (1 << DEST_W);
  localparam int unsigned DestIdxW  = (DestSlots > 1) ? $clog2(DestSlots) : 1;
  localparam int unsigned SlotW     = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
  localparam int unsigned CntW      = $clog2(BATCH_DEPTH + 1);
  localparam int unsigned MemDepth  = DestSlots * BATCH_DEPTH;
  localparam int unsigned AddrW     = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  logic [LIMIT_W-1:0] limit_q;
  logic [LIMIT_W-1:0] eff_limit;

  logic [CntW-1:0] fill_q [DestSlots];

  logic [MSG_BITS-1:0] mem [MemDepth];
  logic [MSG_BITS-1:0] rd_q;

  logic [DEST_W-1:0]   em_dest_q;
  logic [CntW-1:0]     em_n_q;
  logic [CntW-1:0]     em_i_q;
  logic                em_store_q;
  logic [MSG_BITS-1:0] em_msg_q;

  logic              res_valid_q;
  logic              res_has_q;
  logic [DEST_W-1:0] res_dest_q;
  logic              res_last_q;
  logic              res_acc_q;

  logic [DestIdxW-1:0] req_idx;
  logic [DestIdxW-1:0] em_idx;
  logic                dest_ok;
  logic [CntW-1:0]     cur_n;
  logic                full;
  logic                do_emit;
  logic                do_store;
  logic                status_acc;
  logic [CntW-1:0]     fill_new;
  logic                at_last;
  logic [AddrW-1:0]    wr_addr;
  logic [AddrW-1:0]    rd_addr;
  logic                wr_en;
  logic [MSG_BITS-1:0] wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // A limit of zero acts as one, and one above the batch depth as the depth.
  always_comb begin
    eff_limit = limit_q;
    if (limit_q == '0) begin
      eff_limit = LIMIT_W'(1);
    end
    if (int'(limit_q) > BATCH_DEPTH) begin
      eff_limit = LIMIT_W'(BATCH_DEPTH);
    end
  end

  assign req_idx = req_i.dest[DestIdxW-1:0];
  assign em_idx  = em_dest_q[DestIdxW-1:0];
  assign dest_ok = int'(req_i.dest) < NUM_DEST;
  assign cur_n   = dest_ok ? fill_q[req_idx] : '0;
  assign full    = int'(cur_n) >= int'(eff_limit);

  always_comb begin
    do_emit    = 1'b0;
    do_store   = 1'b0;
    status_acc = 1'b1;
    fill_new   = cur_n;
    if (!dest_ok) begin
      status_acc = req_i.mode;
    end else if (req_i.mode == ModeFlush) begin
      fill_new = '0;
      do_emit  = cur_n != '0;
    end else if (full) begin
      if (req_i.link_accepts) begin
        do_emit  = 1'b1;
        fill_new = CntW'(1);
      end else begin
        status_acc = 1'b0;
      end
    end else begin
      do_store = 1'b1;
      fill_new = CntW'(cur_n + 1'b1);
    end
  end

  assign at_last = CntW'(em_i_q + 1'b1) == em_n_q;

  assign sts_o.need_emit = do_emit;
  assign sts_o.at_last   = at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DestSlots; k++) begin
        fill_q[k] <= '0;
      end
    end else if (cmd_i.accept && dest_ok) begin
      fill_q[req_idx] <= fill_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_n_q     <= '0;
      em_i_q     <= '0;
      em_store_q <= 1'b0;
    end else if (cmd_i.accept && do_emit) begin
      em_n_q     <= cur_n;
      em_i_q     <= '0;
      em_store_q <= req_i.mode == ModeSend;
    end else if (cmd_i.emit_step) begin
      em_i_q <= CntW'(em_i_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      em_dest_q <= req_i.dest;
      em_msg_q  <= req_i.message[MSG_BITS-1:0];
    end
  end

  // The message that forced a batch out goes to slot zero once the batch has been read.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AddrW'(int'(req_idx) * BATCH_DEPTH + int'(cur_n));
    wr_data = req_i.message[MSG_BITS-1:0];
    if (cmd_i.emit_step) begin
      wr_en   = at_last && em_store_q;
      wr_addr = AddrW'(int'(em_idx) * BATCH_DEPTH);
      wr_data = em_msg_q;
    end else if (cmd_i.accept && do_store) begin
      wr_en = 1'b1;
    end
  end

  assign rd_addr = AddrW'(int'(em_idx) * BATCH_DEPTH + int'(em_i_q[SlotW-1:0]));

  // Read and write share one block, so a read at the written address sees the old data.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.emit_step) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (cmd_i.accept && !do_emit) || cmd_i.emit_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_step) begin
      res_has_q  <= 1'b1;
      res_dest_q <= em_dest_q;
      res_last_q <= at_last;
      res_acc_q  <= 1'b1;
    end else if (cmd_i.accept) begin
      res_has_q  <= 1'b0;
      res_dest_q <= req_i.dest;
      res_last_q <= 1'b1;
      res_acc_q  <= status_acc;
    end
  end

  assign res_valid_o       = res_valid_q;
  assign res_o.has_message = res_has_q;
  assign res_o.out_dest    = res_dest_q;
  assign res_o.out_message = res_has_q ? MSG_W'(rd_q) : '0;
  assign res_o.last        = res_last_q;
  assign res_o.accepted    = res_acc_q;

endmodule

FILE: rtl/per_destination_message_batcher.sv
// Per-destination message batcher.
// An item is taken on req_i at a rising edge with start_i high and busy_o low.
// A send either stores its message in its destination's batch, or, when that
// batch is full and the link accepts, streams the batch out and stores the new
// message as the first of a fresh batch; a refused send leaves state alone.
// A flush streams the destination's batch out, or gives a status result.
// Results appear on res_o for one cycle each, marked by res_valid_o.
// A status result is registered and shows in the cycle after the item is taken,
// and a new item can be taken in that cycle, so status-only items run back to back.
// A batch keeps busy_o high while it streams out, one slot-store read per cycle,
// after the controller enters its emit state; each message is registered from
// the slot store before it shows on res_o, and no new item is taken meanwhile.
// The user must write the batch limit via cfg_we_i / cfg_wdata_i only while idle;
// the block does not enforce it. Reset clears all fill counts and sets the limit
// to 16; the slot store is not cleared, since only written slots are ever read.
// The receiver cannot stall: each result must be taken in its cycle.
module per_destination_message_batcher
  import pmb_pkg::*;
#(
  parameter int unsigned NUM_DEST    = NumDestDefault,
  parameter int unsigned BATCH_DEPTH = BatchDepthDefault,
  parameter int unsigned MSG_BITS    = MsgBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  input  logic               start_i,
  output logic               busy_o,
  input  pmb_req_t           req_i,
  output logic               res_valid_o,
  output pmb_res_t           res_o
);

  pmb_cmd_t cmd;
  pmb_sts_t sts;

  pmb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  pmb_datapath #(
    .NUM_DEST   (NUM_DEST),
    .BATCH_DEPTH(BATCH_DEPTH),
    .MSG_BITS   (MSG_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule

FILE: tb/sv/batcher_checker.sv
`timescale 1ns / 1ps

// Watches the item and result channels of the batcher, keeps its own copy of
// the fill counts, the slot store and the batch limit, and compares every
// result strobe against the oldest predicted result.
module batcher_checker
  import pmb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  input  logic               start_i,
  input  logic               busy_i,
  input  pmb_req_t           req_i,
  input  logic               res_valid_i,
  input  pmb_res_t           res_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  localparam int Dests = 16;
  localparam int Depth = 16;

  logic [LIMIT_W-1:0] batch_limit;
  logic [LIMIT_W-1:0] fill [Dests];
  logic [MSG_W-1:0]   slots [Dests][Depth];
  pmb_res_t           due_results [$];
  pmb_res_t           want;
  int                 fails = 0;

  assign fail_count_o = fails;

  task automatic flag(string what, logic [MSG_W-1:0] got, logic [MSG_W-1:0] exp_val);
    $display("%0t ns: %s mismatch, got %0h, want %0h", $realtime, what, got, exp_val);
    fails++;
  endtask

  function automatic pmb_res_t status_result(logic [DEST_W-1:0] d, logic acc);
    pmb_res_t r;
    r.has_message = 1'b0;
    r.out_dest    = d;
    r.out_message = '0;
    r.last        = 1'b1;
    r.accepted    = acc;
    return r;
  endfunction

  // Streams one destination's stored batch in slot order and empties it.
  function automatic void stream_batch(logic [DEST_W-1:0] d);
    int n;
    pmb_res_t r;
    n = (fill[d] > Depth) ? Depth : int'(fill[d]);
    for (int i = 0; i < n; i++) begin
      r.has_message = 1'b1;
      r.out_dest    = d;
      r.out_message = slots[d][i];
      r.last        = (i == n - 1);
      r.accepted    = 1'b1;
      due_results.push_back(r);
    end
    fill[d] = '0;
  endfunction

  function automatic void predict_results(pmb_req_t item);
    int lim;
    int n;
    lim = (batch_limit == 0) ? 1 : (batch_limit > Depth) ? Depth : int'(batch_limit);
    n   = int'(fill[item.dest]);
    if (item.mode == ModeFlush) begin
      // The link flag plays no part in a flush.
      if (n == 0) begin
        due_results.push_back(status_result(item.dest, 1'b1));
      end else begin
        stream_batch(item.dest);
      end
    end else if (n >= lim) begin
      // A count above a lowered limit still counts as a full batch.
      if (!item.link_accepts) begin
        due_results.push_back(status_result(item.dest, 1'b0));
      end else begin
        stream_batch(item.dest);
        slots[item.dest][0] = item.message;
        fill[item.dest]     = LIMIT_W'(1);
      end
    end else begin
      slots[item.dest][n] = item.message;
      fill[item.dest]     = LIMIT_W'(n + 1);
      due_results.push_back(status_result(item.dest, 1'b1));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_limit = LimitReset;
      for (int i = 0; i < Dests; i++) fill[i] = '0;
      due_results.delete();
      pending_o <= 0;
    end else begin
      if (res_valid_i) begin
        if (due_results.size() == 0) begin
          flag("unexpected result", res_i.out_message, '0);
        end else begin
          want = due_results.pop_front();
          if (res_i.has_message !== want.has_message)
            flag("has_message", MSG_W'(res_i.has_message), MSG_W'(want.has_message));
          if (res_i.out_dest !== want.out_dest)
            flag("out_dest", MSG_W'(res_i.out_dest), MSG_W'(want.out_dest));
          if (res_i.out_message !== want.out_message)
            flag("out_message", res_i.out_message, want.out_message);
          if (res_i.last !== want.last)
            flag("last", MSG_W'(res_i.last), MSG_W'(want.last));
          if (res_i.accepted !== want.accepted)
            flag("accepted", MSG_W'(res_i.accepted), MSG_W'(want.accepted));
        end
      end
      // An item taken at the same edge as a limit write still sees the old limit.
      if (start_i && !busy_i) predict_results(req_i);
      if (cfg_we_i) batch_limit = cfg_wdata_i;
      pending_o <= due_results.size();
    end
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import pmb_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 40;
  localparam int NumPhases  = 7;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;
  logic               start;
  logic               busy;
  pmb_req_t           req;
  logic               res_valid;
  pmb_res_t           res;
  int                 pending;
  int                 fails;
  int                 cycles = 0;

  per_destination_message_batcher dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .start_i     (start),
    .busy_o      (busy),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  batcher_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .pending_o    (pending),
    .fail_count_o (fails)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic pmb_req_t make_item(logic m, logic [DEST_W-1:0] d,
                                         logic [MSG_W-1:0] msg, logic lnk);
    pmb_req_t r;
    r.mode         = m;
    r.dest         = d;
    r.message      = msg;
    r.link_accepts = lnk;
    return r;
  endfunction

  // Holds start high until the item is taken; start stays high on return.
  task automatic issue(pmb_req_t item);
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [LIMIT_W-1:0] phase_limits [NumPhases];
    logic [DEST_W-1:0]  focus;
    logic [DEST_W-1:0]  d;
    logic [MSG_W-1:0]   msg;
    logic               m;
    logic               lnk;
    int                 sel;

    phase_limits = '{5'd1, 5'd3, 5'd0, 5'd31, 5'd16, 5'd2, 5'd7};
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    start     = 1'b0;
    req       = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting with the reset limit of 16.
    issue(make_item(ModeFlush, 4'd0, '0, 1'b0));
    issue(make_item(ModeSend, 4'd15, '1, 1'b1));
    issue(make_item(ModeSend, 4'd0, '0, 1'b0));
    // A flush ignores a refusing link.
    issue(make_item(ModeFlush, 4'd15, '0, 1'b0));
    issue(make_item(ModeFlush, 4'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1));

    write_limit(5'd2);
    issue(make_item(ModeSend, 4'd3, 64'h5555_5555_5555_5555, 1'b1));
    issue(make_item(ModeSend, 4'd3, {$urandom, $urandom}, 1'b1));
    issue(make_item(ModeSend, 4'd3, {$urandom, $urandom}, 1'b0));
    issue(make_item(ModeSend, 4'd3, {$urandom, $urandom}, 1'b1));
    issue(make_item(ModeFlush, 4'd3, '1, 1'b0));
    issue(make_item(ModeFlush, 4'd3, '0, 1'b1));

    // Lowering the limit below a stored count forces the whole batch out.
    write_limit(5'd4);
    repeat (4) issue(make_item(ModeSend, 4'd7, {$urandom, $urandom}, 1'b1));
    write_limit(5'd1);
    issue(make_item(ModeSend, 4'd7, {$urandom, $urandom}, 1'b1));
    issue(make_item(ModeSend, 4'd7, {$urandom, $urandom}, 1'b0));
    issue(make_item(ModeFlush, 4'd7, {$urandom, $urandom}, 1'b1));

    // Random part: each phase hammers one destination so batches fill up.
    for (int p = 0; p < NumPhases; p++) begin
      write_limit(phase_limits[p]);
      focus = DEST_W'($urandom_range(0, 15));
      for (int k = 0; k < PhaseItems; k++) begin
        if (p != NumPhases - 1 && $urandom_range(0, 3) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        d   = ($urandom_range(0, 2) == 0) ? DEST_W'($urandom_range(0, 15)) : focus;
        m   = ($urandom_range(0, 11) == 0) ? ModeFlush : ModeSend;
        lnk = ($urandom_range(0, 3) != 0);
        sel = $urandom_range(0, 7);
        msg = (sel == 0) ? '1 : (sel == 1) ? '0 : {$urandom, $urandom};
        issue(make_item(m, d, msg, lnk));
      end
    end

    wait_quiet();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
